// ===== sv/source_tokenizer_unit_assert.svh =====
// Assertion macros shared by the tokenizer modules.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef SOURCE_TOKENIZER_UNIT_ASSERT_SVH
`define SOURCE_TOKENIZER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define STOK_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("tokenizer check failed");
`define STOK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed");
`else
`define STOK_ASSERT_ALWAYS(lbl, expr)
`define STOK_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/stok_pkg.sv =====
`timescale 1ns / 1ps
package stok_pkg;

  localparam int POSITION_WIDTH_DEF = 32;
  localparam int LENGTH_WIDTH_DEF   = 16;

  // Token class codes.
  localparam logic [5:0] C_LPAREN    = 6'd0;
  localparam logic [5:0] C_RPAREN    = 6'd1;
  localparam logic [5:0] C_LBRACE    = 6'd2;
  localparam logic [5:0] C_RBRACE    = 6'd3;
  localparam logic [5:0] C_SEMI      = 6'd4;
  localparam logic [5:0] C_COLON     = 6'd5;
  localparam logic [5:0] C_PLUS      = 6'd6;
  localparam logic [5:0] C_DASH      = 6'd7;
  localparam logic [5:0] C_STAR      = 6'd8;
  localparam logic [5:0] C_SLASH     = 6'd9;
  localparam logic [5:0] C_EQUALS    = 6'd10;
  localparam logic [5:0] C_ISEQ      = 6'd11;
  localparam logic [5:0] C_LESS      = 6'd12;
  localparam logic [5:0] C_LESSEQ    = 6'd13;
  localparam logic [5:0] C_GREATER   = 6'd14;
  localparam logic [5:0] C_GREATEREQ = 6'd15;
  localparam logic [5:0] C_NOTEQ     = 6'd16;
  localparam logic [5:0] C_INT       = 6'd17;
  localparam logic [5:0] C_FLOAT     = 6'd18;
  localparam logic [5:0] C_BOOLLIT   = 6'd19;
  localparam logic [5:0] C_CHARLIT   = 6'd20;
  localparam logic [5:0] C_RETURN    = 6'd21;
  localparam logic [5:0] C_FN        = 6'd22;
  localparam logic [5:0] C_LET       = 6'd23;
  localparam logic [5:0] C_I32       = 6'd24;
  localparam logic [5:0] C_I8        = 6'd25;
  localparam logic [5:0] C_F64       = 6'd26;
  localparam logic [5:0] C_BOOL      = 6'd27;
  localparam logic [5:0] C_CHAR      = 6'd28;
  localparam logic [5:0] C_IF        = 6'd29;
  localparam logic [5:0] C_ELSE      = 6'd30;
  localparam logic [5:0] C_IDENT     = 6'd31;
  localparam logic [5:0] C_END       = 6'd32;
  localparam logic [5:0] C_UNKNOWN   = 6'd33;

  localparam int KW_COUNT = 12;

  // Keyword text, first character in the low byte.
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h6e7275746572, 48'h6e66, 48'h74656c, 48'h323369, 48'h3869, 48'h343666,
    48'h6c6f6f62, 48'h72616863, 48'h6669, 48'h65736c65, 48'h65757274,
    48'h65736c6166
  };
  localparam logic [31:0] KW_LEN [KW_COUNT] = '{
    32'd6, 32'd2, 32'd3, 32'd3, 32'd2, 32'd3, 32'd4, 32'd4, 32'd2, 32'd4, 32'd4, 32'd5
  };
  localparam logic [5:0] KW_CLS [KW_COUNT] = '{
    C_RETURN, C_FN, C_LET, C_I32, C_I8, C_F64, C_BOOL, C_CHAR, C_IF, C_ELSE,
    C_BOOLLIT, C_BOOLLIT
  };

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_class;
    logic [31:0] text_start;
    logic [15:0] text_length;
    logic [23:0] line_number;
    logic [15:0] column_number;
  } token_t;

  typedef struct packed {
    logic [5:0]  token_class;
    logic [31:0] text_start;
    logic [15:0] text_length;
    logic [23:0] line_number;
    logic [15:0] column_number;
    logic        final_of_run;
  } out_item_t;

  // All tokens caused by one byte.
  typedef struct packed {
    logic [1:0]       count;
    token_t [2:0]     tok;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_digit(b) || (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
           b == 8'h5f || b == 8'h22 || b == 8'h27;
  endfunction

  // Returns {hit, class} for the single-character symbols.
  function automatic logic [6:0] sym_lookup(input logic [7:0] b);
    logic [6:0] r;
    r = '0;
    case (b)
      8'h28: r = {1'b1, C_LPAREN};
      8'h29: r = {1'b1, C_RPAREN};
      8'h7b: r = {1'b1, C_LBRACE};
      8'h7d: r = {1'b1, C_RBRACE};
      8'h3b: r = {1'b1, C_SEMI};
      8'h3a: r = {1'b1, C_COLON};
      8'h2b: r = {1'b1, C_PLUS};
      8'h2d: r = {1'b1, C_DASH};
      8'h2a: r = {1'b1, C_STAR};
      8'h2f: r = {1'b1, C_SLASH};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Returns {hit, class}; the first matching keyword wins.
  function automatic logic [6:0] kw_lookup(input logic [31:0] n, input logic [47:0] p);
    logic [6:0] r;
    r = '0;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (n == KW_LEN[i] && p == KW_TEXT[i]) r = {1'b1, KW_CLS[i]};
    end
    return r;
  endfunction

endpackage

// ===== sv/stok_front.sv =====
`timescale 1ns / 1ps
module stok_front #(
  parameter int POSITION_WIDTH = stok_pkg::POSITION_WIDTH_DEF,
  parameter int LENGTH_WIDTH   = stok_pkg::LENGTH_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  stok_pkg::in_item_t in_data,
  input  stok_pkg::q_stat_t  q_stat,
  output logic               push,
  output stok_pkg::bundle_t  push_data
);
  import stok_pkg::*;

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_NUMBER = 3'd1;
  localparam logic [2:0] M_WORD   = 3'd2;
  localparam logic [2:0] M_OPER   = 3'd3;
  localparam logic [2:0] M_DONE   = 3'd4;

  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;

  logic [2:0]                mode_r, mode_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [23:0]               line_r, line_nxt;
  logic [15:0]               col_r, col_nxt;
  logic [POSITION_WIDTH-1:0] begin_r, begin_nxt;
  logic [LENGTH_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic                      dot_r, dot_nxt;
  logic [47:0]               prefix_r, prefix_nxt;
  logic                      sq_r, sq_nxt;
  logic                      eq_r, eq_nxt;
  logic                      fire;

  function automatic token_t make_tok(input logic [5:0] c, input logic [POSITION_WIDTH-1:0] s,
                                      input logic [LENGTH_WIDTH-1:0] l,
                                      input logic [23:0] ln, input logic [15:0] cl);
    token_t   t;
    logic [63:0] s64;
    logic [31:0] l32;
    s64 = 64'(s);
    l32 = 32'(l);
    t.token_class   = c;
    t.text_start    = s64[31:0];
    t.text_length   = l32[15:0];
    t.line_number   = ln;
    t.column_number = cl;
    return t;
  endfunction

  // Token for whatever is pending in the given scan state.
  function automatic token_t flush_tok(input logic [2:0] m, input logic [POSITION_WIDTH-1:0] bg,
                                       input logic [LENGTH_WIDTH-1:0] n, input logic dt,
                                       input logic [47:0] p, input logic s, input logic e,
                                       input logic [23:0] ln, input logic [15:0] cl);
    token_t t;
    logic [6:0] kw;
    logic [POSITION_WIDTH-1:0] bg1;
    kw  = kw_lookup(32'(n), p);
    bg1 = bg + POSITION_WIDTH'(1);
    t   = make_tok(C_UNKNOWN, bg, '0, ln, cl);
    if (m == M_NUMBER) begin
      t = make_tok(dt ? C_FLOAT : C_INT, bg, n, ln, cl);
    end else if (m == M_WORD) begin
      if (kw[6]) begin
        t = make_tok(kw[5:0], bg, n, ln, cl);
      end else if (s && e) begin
        if (n == LENGTH_WIDTH'(3)) t = make_tok(C_CHARLIT, bg1, LENGTH_WIDTH'(1), ln, cl);
        else if (n == LENGTH_WIDTH'(4)) t = make_tok(C_CHARLIT, bg1, LENGTH_WIDTH'(2), ln, cl);
        else t = make_tok(C_CHARLIT, bg, '0, ln, cl);
      end else begin
        t = make_tok(C_IDENT, bg, n, ln, cl);
      end
    end else begin
      if (p[7:0] == CH_EQ) t = make_tok(C_EQUALS, bg, LENGTH_WIDTH'(1), ln, cl);
      else if (p[7:0] == CH_LT) t = make_tok(C_LESS, bg, LENGTH_WIDTH'(1), ln, cl);
      else if (p[7:0] == CH_GT) t = make_tok(C_GREATER, bg, LENGTH_WIDTH'(1), ln, cl);
    end
    return t;
  endfunction

  function automatic logic pending(input logic [2:0] m);
    return m == M_NUMBER || m == M_WORD || m == M_OPER;
  endfunction

  assign in_ready = !q_stat.full;
  assign fire     = in_valid && in_ready;

  // One byte of scanning: next state and the tokens the byte causes.
  always_comb begin
    logic [7:0]  b;
    logic        taken;
    logic [1:0]  nt;
    logic [6:0]  sym;
    logic [5:0]  ocls;
    token_t [2:0] tk;
    b          = in_data.byte_value;
    taken      = 1'b0;
    nt         = 2'd0;
    tk         = '0;
    sym        = sym_lookup(b);
    ocls       = C_NOTEQ;
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    begin_nxt  = begin_r;
    cnt_nxt    = cnt_r;
    dot_nxt    = dot_r;
    prefix_nxt = prefix_r;
    sq_nxt     = sq_r;
    eq_nxt     = eq_r;
    if (fire && mode_r != M_DONE) begin
      if (b == 8'h00) begin
        if (pending(mode_r)) begin
          tk[nt] = flush_tok(mode_r, begin_r, cnt_r, dot_r, prefix_r, sq_r, eq_r, line_r, col_r);
          nt = nt + 2'd1;
        end
        tk[nt] = make_tok(C_END, pos_r, '0, line_r, col_r);
        nt = nt + 2'd1;
        mode_nxt = M_DONE;
      end else begin
        // Every nonzero byte is consumed exactly once.
        pos_nxt = pos_r + POSITION_WIDTH'(1);
        if (b == CH_NL) begin
          if (line_r != 24'hFFFFFF) line_nxt = line_r + 24'd1;
          col_nxt = '0;
        end else if (col_r != 16'hFFFF) begin
          col_nxt = col_r + 16'd1;
        end

        // Continue or close the pending token.
        if (mode_r == M_OPER) begin
          if (b == CH_EQ) begin
            if (prefix_r[7:0] == CH_EQ) ocls = C_ISEQ;
            else if (prefix_r[7:0] == CH_LT) ocls = C_LESSEQ;
            else if (prefix_r[7:0] == CH_GT) ocls = C_GREATEREQ;
            tk[nt] = make_tok(ocls, begin_r, LENGTH_WIDTH'(2), line_nxt, col_nxt);
            nt = nt + 2'd1;
            mode_nxt = M_IDLE;
            taken = 1'b1;
          end
        end else if (mode_r == M_NUMBER) begin
          if (is_digit(b) || b == CH_DOT) begin
            if (b == CH_DOT) dot_nxt = 1'b1;
            if (cnt_r != '1) cnt_nxt = cnt_r + LENGTH_WIDTH'(1);
            taken = 1'b1;
          end
        end else if (mode_r == M_WORD) begin
          if (is_word(b)) begin
            if (cnt_r < LENGTH_WIDTH'(6)) prefix_nxt[8*cnt_r[2:0] +: 8] = b;
            eq_nxt = (b == CH_QUOTE);
            if (cnt_r != '1) cnt_nxt = cnt_r + LENGTH_WIDTH'(1);
            taken = 1'b1;
          end
        end
        if (!taken && pending(mode_r)) begin
          tk[nt] = flush_tok(mode_r, begin_r, cnt_r, dot_r, prefix_r, sq_r, eq_r, line_r, col_r);
          nt = nt + 2'd1;
          mode_nxt = M_IDLE;
        end

        // Classify a byte that starts something new.
        if (!taken) begin
          if (b == CH_SP || b == CH_TAB || b == CH_NL) begin
            mode_nxt = M_IDLE;
          end else if (sym[6]) begin
            tk[nt] = make_tok(sym[5:0], pos_r, LENGTH_WIDTH'(1), line_nxt, col_nxt);
            nt = nt + 2'd1;
          end else if (b == CH_EQ || b == CH_LT || b == CH_GT || b == CH_BANG) begin
            begin_nxt  = pos_r;
            cnt_nxt    = LENGTH_WIDTH'(1);
            dot_nxt    = 1'b0;
            prefix_nxt = {40'd0, b};
            sq_nxt     = 1'b0;
            eq_nxt     = 1'b0;
            mode_nxt   = M_OPER;
          end else if (is_digit(b) || b == CH_DOT) begin
            begin_nxt  = pos_r;
            cnt_nxt    = LENGTH_WIDTH'(1);
            dot_nxt    = (b == CH_DOT);
            prefix_nxt = '0;
            sq_nxt     = 1'b0;
            eq_nxt     = 1'b0;
            mode_nxt   = M_NUMBER;
          end else if (is_word(b)) begin
            begin_nxt  = pos_r;
            cnt_nxt    = LENGTH_WIDTH'(1);
            dot_nxt    = 1'b0;
            prefix_nxt = {40'd0, b};
            sq_nxt     = (b == CH_QUOTE);
            eq_nxt     = (b == CH_QUOTE);
            mode_nxt   = M_WORD;
          end else begin
            tk[nt] = make_tok(C_UNKNOWN, pos_r, '0, line_nxt, col_nxt);
            nt = nt + 2'd1;
          end
        end

        // The last byte flushes what it leaves pending and ends the stream.
        if (in_data.is_last) begin
          if (pending(mode_nxt)) begin
            tk[nt] = flush_tok(mode_nxt, begin_nxt, cnt_nxt, dot_nxt, prefix_nxt, sq_nxt,
                               eq_nxt, line_nxt, col_nxt);
            nt = nt + 2'd1;
          end
          tk[nt] = make_tok(C_END, pos_nxt, '0, line_nxt, col_nxt);
          nt = nt + 2'd1;
          mode_nxt = M_DONE;
        end
      end
    end
    push_data.count = nt;
    push_data.tok   = tk;
    push            = nt != 2'd0;
  end

  // Scan state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      line_r   <= '0;
      col_r    <= '0;
      begin_r  <= '0;
      cnt_r    <= '0;
      dot_r    <= 1'b0;
      prefix_r <= '0;
      sq_r     <= 1'b0;
      eq_r     <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      begin_r  <= begin_nxt;
      cnt_r    <= cnt_nxt;
      dot_r    <= dot_nxt;
      prefix_r <= prefix_nxt;
      sq_r     <= sq_nxt;
      eq_r     <= eq_nxt;
    end
  end

endmodule

// ===== sv/stok_queue.sv =====
`timescale 1ns / 1ps
module stok_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  stok_pkg::bundle_t push_data,
  input  logic              pop,
  output stok_pkg::bundle_t head,
  output stok_pkg::q_stat_t q_stat
);
  import stok_pkg::*;

  `include "source_tokenizer_unit_assert.svh"

  bundle_t    mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] fill_r;

  assign head         = mem_r[rd_r];
  assign q_stat.full  = fill_r == 2'd2;
  assign q_stat.empty = fill_r == 2'd0;

  // Bundle storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= 1'b0;
      rd_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `STOK_ASSERT_ALWAYS(a_fill_bound, fill_r <= 2'd2)
  `STOK_ASSERT_ALWAYS(a_no_pop_empty, !(pop && q_stat.empty))
  `STOK_ASSERT_ALWAYS(a_no_push_full, !(push && q_stat.full))
  `STOK_ASSERT_NEXT(a_push_visible, push && !pop, !q_stat.empty)

endmodule

// ===== sv/stok_back.sv =====
`timescale 1ns / 1ps
module stok_back (
  input  logic                clk,
  input  logic                rst_n,
  input  stok_pkg::bundle_t   head,
  input  stok_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output stok_pkg::out_item_t out_data
);
  import stok_pkg::*;

  `include "source_tokenizer_unit_assert.svh"

  logic [1:0] idx_r;
  logic       last_tok;
  token_t     cur;

  assign cur       = head.tok[idx_r];
  assign last_tok  = idx_r == head.count - 2'd1;
  assign out_valid = !q_stat.empty;
  assign pop       = out_valid && out_ready && last_tok;

  assign out_data.token_class   = cur.token_class;
  assign out_data.text_start    = cur.text_start;
  assign out_data.text_length   = cur.text_length;
  assign out_data.line_number   = cur.line_number;
  assign out_data.column_number = cur.column_number;
  assign out_data.final_of_run  = last_tok;

  // Walk through the tokens of the head bundle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx_r <= last_tok ? 2'd0 : idx_r + 2'd1;
    end
  end

  `STOK_ASSERT_ALWAYS(a_idx_in_bundle, q_stat.empty || idx_r < head.count)
  `STOK_ASSERT_ALWAYS(a_idx_zero_idle, !q_stat.empty || idx_r == 2'd0)
  `STOK_ASSERT_NEXT(a_step_index, out_valid && out_ready && !last_tok, idx_r != 2'd0)

endmodule

// ===== sv/source_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// Streaming source tokenizer. One source byte is accepted per cycle while
// in_ready is high; each byte yields zero to three tokens, delivered one per
// cycle on the result channel while out_ready is high, with final_of_run set
// on the last token a byte causes. A byte's tokens go into a two-entry queue,
// so in_ready falls only when that queue is full, which happens when bytes
// cause tokens faster than the result side takes them. A token is delivered
// at the earliest in the cycle after its byte is accepted. After a zero byte
// or a byte marked is_last the block ignores all input until reset.
module source_tokenizer_unit #(
  parameter int POSITION_WIDTH = stok_pkg::POSITION_WIDTH_DEF,
  parameter int LENGTH_WIDTH   = stok_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stok_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stok_pkg::out_item_t out_data
);
  import stok_pkg::*;

  q_stat_t q_stat;
  logic    push, pop;
  bundle_t push_data, head;

  stok_front #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .LENGTH_WIDTH  (LENGTH_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  stok_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  stok_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import stok_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_NUMBER, S_WORD, S_OPER, S_DONE} scan_e;

  typedef struct {
    logic [7:0] b;
    logic       known;
    logic [5:0] cls;
  } directed_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int errors = 0;
  int stall_pct = 0;

  // Scanner state mirrored by the predictor.
  scan_e       mode;
  logic [31:0] pos;
  logic [23:0] line;
  logic [15:0] col;
  logic [31:0] tok_begin;
  logic [15:0] tok_count;
  logic        dot_seen;
  logic [47:0] prefix;
  logic        open_quote;
  logic        close_quote;

  out_item_t tokens_due[$];
  out_item_t step_tokens[$];
  logic [5:0] last_class;

  in_item_t request_list[$];
  int       chunk_end[4];

  string      kw_word[12] = '{"return", "fn", "let", "i32", "i8", "f64", "bool", "char",
                              "if", "else", "true", "false"};
  logic [5:0] kw_class[12] = '{C_RETURN, C_FN, C_LET, C_I32, C_I8, C_F64, C_BOOL, C_CHAR,
                               C_IF, C_ELSE, C_BOOLLIT, C_BOOLLIT};

  source_tokenizer_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Hard limit on run time.
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic digit_char(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic word_char(logic [7:0] b);
    return digit_char(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           b == "_" || b == 8'h22 || b == 8'h27;
  endfunction

  function automatic void add_token(logic [5:0] cls, logic [31:0] start, logic [15:0] len);
    out_item_t t;
    t.token_class   = cls;
    t.text_start    = start;
    t.text_length   = len;
    t.line_number   = line;
    t.column_number = col;
    t.final_of_run  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void advance(logic [7:0] b);
    pos = pos + 32'd1;
    if (b == 8'h0a) begin
      if (line != 24'hFFFFFF) line = line + 24'd1;
      col = '0;
    end else if (col != 16'hFFFF) begin
      col = col + 16'd1;
    end
  endfunction

  function automatic void start_token();
    tok_begin   = pos;
    tok_count   = 16'd1;
    dot_seen    = 1'b0;
    prefix      = '0;
    open_quote  = 1'b0;
    close_quote = 1'b0;
  endfunction

  // Emit whatever token is pending in the current mode.
  function automatic void flush_pending();
    logic [47:0] kw_bits;
    logic        matched;
    matched = 1'b0;
    case (mode)
      S_NUMBER: add_token(dot_seen ? C_FLOAT : C_INT, tok_begin, tok_count);
      S_WORD: begin
        for (int i = 0; i < 12; i++) begin
          kw_bits = '0;
          for (int k = 0; k < kw_word[i].len() && k < 6; k++)
            kw_bits[8*k +: 8] = kw_word[i][k];
          if (!matched && tok_count == kw_word[i].len() && prefix == kw_bits) begin
            add_token(kw_class[i], tok_begin, tok_count);
            matched = 1'b1;
          end
        end
        if (!matched) begin
          if (open_quote && close_quote) begin
            if (tok_count == 16'd3) add_token(C_CHARLIT, tok_begin + 32'd1, 16'd1);
            else if (tok_count == 16'd4) add_token(C_CHARLIT, tok_begin + 32'd1, 16'd2);
            else add_token(C_CHARLIT, tok_begin, 16'd0);
          end else begin
            add_token(C_IDENT, tok_begin, tok_count);
          end
        end
      end
      S_OPER: begin
        if (prefix[7:0] == "=") add_token(C_EQUALS, tok_begin, 16'd1);
        else if (prefix[7:0] == "<") add_token(C_LESS, tok_begin, 16'd1);
        else if (prefix[7:0] == ">") add_token(C_GREATER, tok_begin, 16'd1);
        else add_token(C_UNKNOWN, tok_begin, 16'd0);
      end
      default: ;
    endcase
    mode = S_IDLE;
  endfunction

  // Works out the tokens one accepted request causes and queues them.
  function automatic void predict_tokens(in_item_t it);
    logic [7:0]  b;
    logic        taken;
    logic [31:0] here;
    logic [6:0]  sym;
    out_item_t   t;
    b = it.byte_value;
    taken = 1'b0;
    step_tokens.delete();
    if (mode == S_DONE) return;
    if (b == 8'h00) begin
      flush_pending();
      add_token(C_END, pos, 16'd0);
      mode = S_DONE;
    end else begin
      if (mode == S_OPER) begin
        if (b == "=") begin
          advance(b);
          add_token(prefix[7:0] == "=" ? C_ISEQ : prefix[7:0] == "<" ? C_LESSEQ :
                    prefix[7:0] == ">" ? C_GREATEREQ : C_NOTEQ, tok_begin, 16'd2);
          mode = S_IDLE;
          taken = 1'b1;
        end else flush_pending();
      end else if (mode == S_NUMBER) begin
        if (digit_char(b) || b == ".") begin
          if (b == ".") dot_seen = 1'b1;
          if (tok_count != 16'hFFFF) tok_count = tok_count + 16'd1;
          advance(b);
          taken = 1'b1;
        end else flush_pending();
      end else if (mode == S_WORD) begin
        if (word_char(b)) begin
          if (tok_count < 6) prefix[8*tok_count +: 8] = b;
          close_quote = (b == 8'h27);
          if (tok_count != 16'hFFFF) tok_count = tok_count + 16'd1;
          advance(b);
          taken = 1'b1;
        end else flush_pending();
      end
      if (!taken) begin
        here = pos;
        sym = '0;
        case (b)
          "(": sym = {1'b1, C_LPAREN};
          ")": sym = {1'b1, C_RPAREN};
          "{": sym = {1'b1, C_LBRACE};
          "}": sym = {1'b1, C_RBRACE};
          ";": sym = {1'b1, C_SEMI};
          ":": sym = {1'b1, C_COLON};
          "+": sym = {1'b1, C_PLUS};
          "-": sym = {1'b1, C_DASH};
          "*": sym = {1'b1, C_STAR};
          "/": sym = {1'b1, C_SLASH};
          default: ;
        endcase
        if (b == " " || b == 8'h09 || b == 8'h0a) begin
          advance(b);
        end else if (sym[6]) begin
          advance(b);
          add_token(sym[5:0], here, 16'd1);
        end else if (b == "=" || b == "<" || b == ">" || b == "!") begin
          start_token();
          prefix = {40'd0, b};
          mode = S_OPER;
          advance(b);
        end else if (digit_char(b) || b == ".") begin
          start_token();
          dot_seen = (b == ".");
          mode = S_NUMBER;
          advance(b);
        end else if (word_char(b)) begin
          start_token();
          prefix = {40'd0, b};
          open_quote = (b == 8'h27);
          close_quote = (b == 8'h27);
          mode = S_WORD;
          advance(b);
        end else begin
          advance(b);
          add_token(C_UNKNOWN, here, 16'd0);
        end
      end
      if (it.is_last) begin
        flush_pending();
        add_token(C_END, pos, 16'd0);
        mode = S_DONE;
      end
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.final_of_run = 1'b1;
      step_tokens.push_back(t);
      last_class = t.token_class;
    end
    foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
  endfunction

  // Offers one request, with random idle cycles first, and waits until it is taken.
  task automatic send_request(in_item_t it, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tokens(it);
  endtask

  function automatic void push_text(string s);
    in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.byte_value = s[i];
      it.is_last = 1'b0;
      request_list.push_back(it);
    end
  endfunction

  function automatic void push_byte(logic [7:0] b);
    in_item_t it;
    it.byte_value = b;
    it.is_last = 1'b0;
    request_list.push_back(it);
  endfunction

  function automatic logic [7:0] random_word_char();
    case ($urandom_range(0, 3))
      0: return 8'h61 + 8'($urandom_range(0, 25));
      1: return 8'h41 + 8'($urandom_range(0, 25));
      2: return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'h5f;
    endcase
  endfunction

  // Appends one random source fragment, mostly well-formed tokens.
  function automatic void push_fragment();
    string ops[8] = '{"=", "==", "<", "<=", ">", ">=", "!=", "!"};
    string syms = "(){};:+-*/";
    int n;
    case ($urandom_range(0, 12))
      0, 1: push_text(kw_word[$urandom_range(0, 11)]);
      2: begin
        push_text(kw_word[$urandom_range(0, 11)]);
        push_byte(random_word_char());
      end
      3, 4: begin
        push_byte(8'h61 + 8'($urandom_range(0, 25)));
        n = $urandom_range(0, 8);
        repeat (n) push_byte(random_word_char());
      end
      5: begin
        n = $urandom_range(1, 5);
        repeat (n) push_byte($urandom_range(0, 4) == 0 ? 8'h2e : 8'h30 + 8'($urandom_range(0, 9)));
      end
      6: begin
        // Quoted word; zero to three inner characters.
        push_byte(8'h27);
        n = $urandom_range(0, 3);
        repeat (n) push_byte($urandom_range(0, 5) == 0 ? 8'h22 : random_word_char());
        if ($urandom_range(0, 4) != 0) push_byte(8'h27);
      end
      7, 8: push_text(ops[$urandom_range(0, 7)]);
      9: push_byte(syms[$urandom_range(0, 9)]);
      10: push_byte(8'h0a);
      11: push_byte(8'($urandom_range(1, 255)));
      default: push_byte(8'($urandom_range(128, 255)));
    endcase
    case ($urandom_range(0, 5))
      0, 1: push_byte(" ");
      2: push_byte(8'h09);
      default: ;
    endcase
  endfunction

  // Result checker: each accepted token against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        $display("%0t: unexpected token, actual %p", $time, out_data);
        errors++;
      end else begin
        want = tokens_due.pop_front();
        if (out_data.token_class !== want.token_class ||
            out_data.text_start !== want.text_start ||
            out_data.text_length !== want.text_length ||
            out_data.line_number !== want.line_number ||
            out_data.column_number !== want.column_number ||
            out_data.final_of_run !== want.final_of_run) begin
          $display("%0t: token mismatch, expected %p, actual %p", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    directed_row_t rows[20];
    in_item_t it;
    int idle_pct;
    int phase;
    int wait_cycles;

    rows = '{
      '{"(", 1, C_LPAREN}, '{")", 1, C_RPAREN}, '{"{", 1, C_LBRACE}, '{"}", 1, C_RBRACE},
      '{";", 1, C_SEMI}, '{":", 1, C_COLON}, '{"+", 1, C_PLUS}, '{"-", 1, C_DASH},
      '{"*", 1, C_STAR}, '{"/", 1, C_SLASH},
      '{"=", 0, 0}, '{"=", 1, C_ISEQ},
      '{"<", 0, 0}, '{" ", 1, C_LESS},
      '{">", 0, 0}, '{"=", 1, C_GREATEREQ},
      '{"!", 0, 0}, '{"x", 1, C_UNKNOWN},
      '{8'hff, 1, C_UNKNOWN}, '{8'h0d, 1, C_UNKNOWN}
    };

    mode = S_IDLE;
    pos = '0; line = '0; col = '0; tok_begin = '0; tok_count = '0;
    dot_seen = 0; prefix = '0; open_quote = 0; close_quote = 0;

    // Build the random stream in four chunks, one per idling phase.
    for (int c = 0; c < 4; c++) begin
      while (request_list.size() < (c == 0 ? 0 : chunk_end[c-1]) + 52) push_fragment();
      chunk_end[c] = request_list.size();
    end
    // End the stream either with a zero byte or with a marked last byte.
    if ($urandom_range(0, 1) == 0) begin
      push_byte(8'h00);
    end else begin
      it = request_list.pop_back();
      it.is_last = 1'b1;
      request_list.push_back(it);
    end
    chunk_end[3] = request_list.size();
    // A request after the end must cause nothing.
    push_byte(8'($urandom_range(1, 255)));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests with hand-read classes cross-checked.
    foreach (rows[i]) begin
      it.byte_value = rows[i].b;
      it.is_last = 1'b0;
      send_request(it, 0);
      if (rows[i].known && (step_tokens.size() == 0 || last_class !== rows[i].cls)) begin
        $display("%0t: directed request %0d, expected class %0d, actual %0d",
                 $time, i, rows[i].cls, step_tokens.size() == 0 ? -1 : last_class);
        errors++;
      end
    end

    // Random stream, phase by phase.
    phase = 0;
    foreach (request_list[i]) begin
      if (i == chunk_end[0] || i == chunk_end[1] || i == chunk_end[2]) begin
        phase++;
        if (phase == 2) begin
          // Hold off the sender until every token has been delivered.
          in_valid <= 1'b0;
          @(posedge clk);
          while (tokens_due.size() != 0) @(posedge clk);
        end
      end
      case (phase)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 67; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 67; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      send_request(request_list[i], idle_pct);
    end
    in_valid <= 1'b0;
    stall_pct = 0;

    wait_cycles = 0;
    while (tokens_due.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);

    if (errors == 0 && tokens_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (tokens_due.size() != 0)
        $display("%0t: %0d expected tokens never arrived", $time, tokens_due.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
